@@ hw/rtl/rtsd_pkg.sv @@
package rtsd_pkg;

   // Event codes carried in the input tuser
   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_MODE   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RUN_START = 3'b001,
      RUN_RUN   = 3'b010,
      RUN_PAUSE = 3'b100
   } run_state_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_MM    = 2'd1,
      KIND_FI    = 2'd2
   } kind_type;

   // Two decimal pairs (0..99 each) ready for digit split and segment encode
   typedef struct packed {
      logic [6:0] hi;
      logic [6:0] lo;
      logic       colon;
      logic       blank_en;
   } pair_type;

   localparam logic [7:0]  COLON_BIT  = 8'b1000_0000;
   localparam logic [3:0]  BLANK_CODE = 4'd10;
   localparam logic [13:0] MM_MAX     = 14'd9999;

   // floor(x/250)  = (x * MM_RECIP) >> 32, exact for x < 2^24
   // floor(x/2500) = (x * FI_RECIP) >> 36, exact for x < 2^24
   localparam logic [24:0] MM_RECIP   = 25'd17179870;
   localparam int          MM_SHIFT   = 32;
   localparam logic [24:0] FI_RECIP   = 25'd27487791;
   localparam int          FI_SHIFT   = 36;
   // floor(50d/127) = (d * 50 * 528417) >> 26
   localparam logic [24:0] INCH_RECIP = 25'd26420850;
   localparam int          INCH_SHIFT = 26;

   function automatic logic [6:0] seg_encode(input logic [3:0] digit);
      logic [6:0] seg;
      unique case (digit)
         4'd0:    seg = 7'b011_1111;
         4'd1:    seg = 7'b000_0110;
         4'd2:    seg = 7'b101_1011;
         4'd3:    seg = 7'b100_1111;
         4'd4:    seg = 7'b110_0110;
         4'd5:    seg = 7'b110_1101;
         4'd6:    seg = 7'b111_1101;
         4'd7:    seg = 7'b000_0111;
         4'd8:    seg = 7'b111_1111;
         4'd9:    seg = 7'b110_1111;
         default: seg = 7'b000_0000;
      endcase
      return seg;
   endfunction

endpackage

@@ hw/rtl/range_to_seven_segment_display.sv @@
// Ranger-to-display converter. Each input item is either a distance sample
// (tuser 0, raw count in tdata) or a button event (tuser 1 start/pause,
// tuser 2 unit toggle; tuser 3 is ignored). Button events only change the
// internal run state and unit mode and give no result. A sample gives one
// result of four segment bytes unless the block is paused: "00:00" with the
// colon before the first start press, raw/250 capped at 9999 in unit mode 0,
// and feet:inches in unit mode 1 (the mode after reset). Outside the start
// screen leading zeros are blanked; the rightmost digit always shows. The
// block takes one item per clock unless backpressure holds req_tready low;
// a sample's result passes through five register stages (input, loaded at
// the accepting edge, then constant-reciprocal divide, unit scaling, decimal
// pair split, segment encode). Backpressure stalls only stages that are
// full, so bubbles still absorb new items while a result waits.
module range_to_seven_segment_display (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] raw_distance
   input  logic [1:0]  req_tuser,   // [1:0] cmd

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] seg_rightmost, [15:8] seg_right_middle,
                                    // [23:16] seg_left_middle, [31:24] seg_leftmost
);

   // ---------------- handshake / stage control ----------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, s5_vld_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic req_accept;

   assign rdy5 = !s5_vld_ff || rsp_tready;
   assign rdy4 = !s4_vld_ff || rdy5;
   assign rdy3 = !s3_vld_ff || rdy4;
   assign rdy2 = !s2_vld_ff || rdy3;
   assign rdy1 = !s1_vld_ff || rdy2;

   assign req_tready = rdy1;
   assign req_accept = req_tvalid && req_tready;

   // ---------------- mode state ----------------
   rtsd_pkg::cmd_type       cmd;
   rtsd_pkg::run_state_type run_state_ff, run_state_in;
   logic                    unit_mode_ff, unit_mode_in;
   logic                    sample_out;   // a sample in the current state yields a result
   rtsd_pkg::kind_type      kind;

   assign cmd = rtsd_pkg::cmd_type'(req_tuser);

   always_comb begin
      run_state_in = run_state_ff;
      unit_mode_in = unit_mode_ff;
      if (req_accept) begin
         unique case (cmd)
            rtsd_pkg::CMD_START: begin
               run_state_in = (run_state_ff == rtsd_pkg::RUN_RUN) ?
                              rtsd_pkg::RUN_PAUSE : rtsd_pkg::RUN_RUN;
            end
            rtsd_pkg::CMD_MODE: begin
               unit_mode_in = !unit_mode_ff;
            end
            rtsd_pkg::CMD_SAMPLE, rtsd_pkg::CMD_NONE: begin
            end
         endcase
      end
   end

   // what a sample becomes in the current state
   always_comb begin
      sample_out = 1'b1;
      kind       = unit_mode_ff ? rtsd_pkg::KIND_FI : rtsd_pkg::KIND_MM;
      unique case (run_state_ff)
         rtsd_pkg::RUN_START: kind = rtsd_pkg::KIND_START;
         rtsd_pkg::RUN_PAUSE: sample_out = 1'b0;
         default: ;   // run
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_state_ff <= rtsd_pkg::RUN_START;
         unit_mode_ff <= 1'b1;
      end else begin
         run_state_ff <= run_state_in;
         unit_mode_ff <= unit_mode_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic [23:0]        s1_raw_ff;
   rtsd_pkg::kind_type s1_kind_ff;

   assign s1_vld_in = rdy1 ? (req_accept && cmd == rtsd_pkg::CMD_SAMPLE && sample_out)
                           : s1_vld_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_raw_ff  <= req_tdata;
         s1_kind_ff <= kind;
      end
   end

   // ---------------- stage 2: raw/250 or raw/2500 ----------------
   logic [24:0]        div_recip;
   logic [48:0]        div_prod;
   logic [16:0]        quot;
   logic [16:0]        s2_quot_ff;
   rtsd_pkg::kind_type s2_kind_ff;

   assign div_recip = (s1_kind_ff == rtsd_pkg::KIND_FI) ? rtsd_pkg::FI_RECIP
                                                         : rtsd_pkg::MM_RECIP;
   assign div_prod  = {25'b0, s1_raw_ff} * {24'b0, div_recip};
   assign quot      = (s1_kind_ff == rtsd_pkg::KIND_FI) ?
                      {4'b0, div_prod[48:rtsd_pkg::FI_SHIFT]} :
                      div_prod[48:rtsd_pkg::MM_SHIFT];
   assign s2_vld_in = rdy2 ? s1_vld_ff : s2_vld_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_quot_ff <= quot;
         s2_kind_ff <= s1_kind_ff;
      end
   end

   // ---------------- stage 3: cap, or total inches ----------------
   logic [37:0]        inch_prod;
   logic [13:0]        val;
   logic [13:0]        s3_val_ff;
   rtsd_pkg::kind_type s3_kind_ff;

   assign inch_prod = {25'b0, s2_quot_ff[12:0]} * {13'b0, rtsd_pkg::INCH_RECIP};

   always_comb begin
      if (s2_kind_ff == rtsd_pkg::KIND_FI) begin
         val = {2'b0, inch_prod[37:rtsd_pkg::INCH_SHIFT]};
      end else if (s2_quot_ff > {3'b0, rtsd_pkg::MM_MAX}) begin
         val = rtsd_pkg::MM_MAX;
      end else begin
         val = s2_quot_ff[13:0];
      end
   end

   assign s3_vld_in = rdy3 ? s2_vld_ff : s3_vld_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_val_ff  <= val;
         s3_kind_ff <= s2_kind_ff;
      end
   end

   // ---------------- stage 4: split into two decimal pairs ----------------
   logic [24:0]        hund_prod;   // (val>>2) * 5243 >> 17 = val/100
   logic [6:0]         hund;
   logic [13:0]        hund_rem;
   logic [19:0]        feet_prod;   // (t>>2) * 683 >> 11 = t/12
   logic [7:0]         feet;
   logic [7:0]         feet_mod;
   logic [11:0]        inch_rem;
   rtsd_pkg::pair_type pair;
   rtsd_pkg::pair_type s4_pair_ff;

   assign hund_prod = {13'b0, s3_val_ff[13:2]} * 25'd5243;
   assign hund      = hund_prod[23:17];
   assign hund_rem  = s3_val_ff - 14'({7'b0, hund} * 14'd100);

   assign feet_prod = {10'b0, s3_val_ff[11:2]} * 20'd683;
   assign feet      = feet_prod[18:11];
   assign inch_rem  = s3_val_ff[11:0] - 12'({4'b0, feet} * 12'd12);

   always_comb begin
      priority if (feet >= 8'd200) begin
         feet_mod = feet - 8'd200;
      end else if (feet >= 8'd100) begin
         feet_mod = feet - 8'd100;
      end else begin
         feet_mod = feet;
      end
   end

   always_comb begin
      unique case (s3_kind_ff)
         rtsd_pkg::KIND_MM: begin
            pair.hi       = hund;
            pair.lo       = hund_rem[6:0];
            pair.colon    = 1'b0;
            pair.blank_en = 1'b1;
         end
         rtsd_pkg::KIND_FI: begin
            pair.hi       = feet_mod[6:0];
            pair.lo       = {3'b0, inch_rem[3:0]};
            pair.colon    = 1'b1;
            pair.blank_en = 1'b1;
         end
         default: begin   // start: 00:00, nothing blanked
            pair.hi       = 7'd0;
            pair.lo       = 7'd0;
            pair.colon    = 1'b1;
            pair.blank_en = 1'b0;
         end
      endcase
   end

   assign s4_vld_in = rdy4 ? s3_vld_ff : s4_vld_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_pair_ff <= pair;
      end
   end

   // ---------------- stage 5: digits, blanking, segments ----------------
   logic [31:0] seg;
   logic [31:0] rsp_data_ff;

   rtsd_digits u_digits (
      .pair_i (s4_pair_ff),
      .seg_o  (seg)
   );

   assign s5_vld_in = rdy5 ? s4_vld_ff : s5_vld_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_data_ff <= seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
         s5_vld_ff <= s5_vld_in;
      end
   end

   assign rsp_tvalid = s5_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   // rightmost digit is never blanked
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] != 7'd0)
      else $error("rightmost digit blank");

   // colon bit is the same on all four bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7] == rsp_tdata[15] && rsp_tdata[7] == rsp_tdata[23]
                      && rsp_tdata[7] == rsp_tdata[31]))
      else $error("colon bits differ");

   // a sample taken while paused never enters the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == rtsd_pkg::CMD_SAMPLE && run_state_ff == rtsd_pkg::RUN_PAUSE)
      |=> !s1_vld_ff)
      else $error("paused sample entered pipeline");

   // unit toggle flips the mode
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == rtsd_pkg::CMD_MODE) |=> unit_mode_ff != $past(unit_mode_ff))
      else $error("unit mode did not toggle");

endmodule

@@ hw/rtl/rtsd_digits.sv @@
module rtsd_digits (
   input  rtsd_pkg::pair_type pair_i,
   output logic [31:0]        seg_o   // rightmost, right middle, left middle, leftmost
);

   logic [14:0] hi_prod;
   logic [14:0] lo_prod;
   logic [3:0]  d3, d2, d1, d0;
   logic [6:0]  hi_rem;
   logic [6:0]  lo_rem;
   logic [3:0]  e3, e2, e1;
   logic [7:0]  colon;

   // x/10 for x < 100 as (x * 205) >> 11
   assign hi_prod = {8'b0, pair_i.hi} * 15'd205;
   assign lo_prod = {8'b0, pair_i.lo} * 15'd205;
   assign d3      = hi_prod[14:11];
   assign d1      = lo_prod[14:11];
   assign hi_rem  = pair_i.hi - 7'({3'b0, d3} * 7'd10);
   assign lo_rem  = pair_i.lo - 7'({3'b0, d1} * 7'd10);
   assign d2      = hi_rem[3:0];
   assign d0      = lo_rem[3:0];

   // leading-zero blanking; rightmost digit always shown
   always_comb begin
      e3 = d3;
      e2 = d2;
      e1 = d1;
      if (pair_i.blank_en && d3 == 4'd0) begin
         e3 = rtsd_pkg::BLANK_CODE;
         if (d2 == 4'd0) begin
            e2 = rtsd_pkg::BLANK_CODE;
            if (d1 == 4'd0) begin
               e1 = rtsd_pkg::BLANK_CODE;
            end
         end
      end
   end

   assign colon = pair_i.colon ? rtsd_pkg::COLON_BIT : 8'h00;

   assign seg_o = {colon | {1'b0, rtsd_pkg::seg_encode(e3)},
                   colon | {1'b0, rtsd_pkg::seg_encode(e2)},
                   colon | {1'b0, rtsd_pkg::seg_encode(e1)},
                   colon | {1'b0, rtsd_pkg::seg_encode(d0)}};

endmodule

@@ test/range_to_seven_segment_display_test.sv @@
// Display model and result checker. Holds its own copy of the run state and
// unit mode, and the queue of segment words that samples are due to produce.
class display_scoreboard;
   logic [31:0]            pending_displays[$];
   rtsd_pkg::run_state_type run_state;
   bit                     unit_mode;
   int unsigned            mismatches;

   function new();
      run_state  = rtsd_pkg::RUN_START;
      unit_mode  = 1'b1;
      mismatches = 0;
   endfunction

   // segments g..a for a decimal digit; anything else is a blank
   function logic [6:0] glyph(int unsigned digit);
      case (digit)
         0:       return 7'h3F;
         1:       return 7'h06;
         2:       return 7'h5B;
         3:       return 7'h4F;
         4:       return 7'h66;
         5:       return 7'h6D;
         6:       return 7'h7D;
         7:       return 7'h07;
         8:       return 7'h7F;
         9:       return 7'h6F;
         default: return 7'h00;
      endcase
   endfunction

   // four digits, leftmost first; leading zeros blanked, rightmost always lit
   function logic [31:0] render(int unsigned d3, int unsigned d2, int unsigned d1,
                                int unsigned d0, bit colon);
      int unsigned dig[4];
      bit          leading;
      logic [31:0] word;
      dig[0]  = d0 % 10;
      dig[1]  = d1 % 10;
      dig[2]  = d2 % 10;
      dig[3]  = d3 % 10;
      leading = 1'b1;
      for (int k = 3; k >= 1; k--) begin
         if (leading && dig[k] == 0) dig[k] = 10;
         else leading = 1'b0;
      end
      for (int k = 0; k < 4; k++) word[k*8 +: 8] = {colon, glyph(dig[k])};
      return word;
   endfunction

   function void note_item(rtsd_pkg::cmd_type cmd, logic [23:0] raw);
      int unsigned counts;
      int unsigned tenths;
      int unsigned feet;
      int unsigned inches;
      case (cmd)
         rtsd_pkg::CMD_START: begin
            run_state = (run_state == rtsd_pkg::RUN_RUN) ? rtsd_pkg::RUN_PAUSE
                                                          : rtsd_pkg::RUN_RUN;
         end
         rtsd_pkg::CMD_MODE: begin
            unit_mode = ~unit_mode;
         end
         rtsd_pkg::CMD_SAMPLE: begin
            if (run_state == rtsd_pkg::RUN_START) begin
               pending_displays.push_back({4{1'b1, glyph(0)}});
            end else if (run_state != rtsd_pkg::RUN_PAUSE) begin
               if (!unit_mode) begin
                  counts = raw / 250;
                  if (counts > 9999) counts = 9999;
                  pending_displays.push_back(render(counts / 1000, counts / 100,
                                                    counts / 10, counts, 1'b0));
               end else begin
                  tenths = raw / 2500;
                  feet   = (50 * tenths) / 1524;
                  inches = (50 * tenths) / 127 - 12 * feet;
                  pending_displays.push_back(render(feet / 10, feet, inches / 10,
                                                    inches, 1'b1));
               end
            end
         end
         default: ;
      endcase
   endfunction

   function string field_name(int k);
      case (k)
         0:       return "seg_rightmost";
         1:       return "seg_right_middle";
         2:       return "seg_left_middle";
         default: return "seg_leftmost";
      endcase
   endfunction

   function void check_display(logic [31:0] seen);
      logic [31:0] want;
      if (pending_displays.size() == 0) begin
         $error("result %h with none pending", seen);
         mismatches++;
         return;
      end
      want = pending_displays.pop_front();
      for (int k = 0; k < 4; k++) begin
         if (seen[k*8 +: 8] !== want[k*8 +: 8]) begin
            $error("%s: expected %h, actual %h", field_name(k),
                   want[k*8 +: 8], seen[k*8 +: 8]);
            mismatches++;
         end
      end
   endfunction
endclass

module range_to_seven_segment_display_test;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no item moving on either side before the run is called hung
   localparam int STALL_LIMIT = 5000;
   // drain time after the last expected result (pipeline is 5 deep)
   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [23:0] raw_distance
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [7:0] seg_rightmost, [15:8] seg_right_middle,
                             // [23:16] seg_left_middle, [31:24] seg_leftmost

   display_scoreboard scoreboard;

   // percent of cycles each side spends idle, changed per phase
   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned stall_cycles;

   range_to_seven_segment_display u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: tready is redrawn at every falling edge, once per step.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Result monitor. Reads at the rising edge see pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_display(rsp_tdata);
   end

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Present one item and hold it until the block takes it. Idle gaps come
   // first, so a gap can land behind any item. tvalid gets a single
   // assignment per falling edge, so back-to-back items never glitch it.
   task automatic send_item(rtsd_pkg::cmd_type cmd, logic [23:0] raw);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.note_item(cmd, raw);
   endtask

   // Random mix, mostly samples. Start/pause presses keep the block hopping
   // between run and pause, mode presses between the two unit displays.
   // Raw counts mix full-range values (feet past 99, mode 0 saturation),
   // the unsaturated mode 0 range, short distances (blanked digits) and
   // counts right at the divisor steps.
   task automatic random_items(int unsigned count);
      int unsigned        counted;
      int unsigned        pick;
      rtsd_pkg::cmd_type  cmd;
      logic [23:0]        raw;
      counted = 0;
      while (counted < count) begin
         pick = $urandom_range(99);
         if (pick < 72)      cmd = rtsd_pkg::CMD_SAMPLE;
         else if (pick < 84) cmd = rtsd_pkg::CMD_START;
         else if (pick < 95) cmd = rtsd_pkg::CMD_MODE;
         else                cmd = rtsd_pkg::CMD_NONE;
         case ($urandom_range(3))
            0:       raw = 24'($urandom());
            1:       raw = 24'($urandom_range(2500000));
            2:       raw = 24'($urandom_range(30000));
            default: raw = 24'(($urandom_range(1) ? 250 : 2500) * $urandom_range(4000)
                               + $urandom_range(2) - 1);
         endcase
         send_item(cmd, raw);
         counted++;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rtsd_pkg::CMD_NONE;
      send_idle  = 7;
      recv_idle  = 85;
      scoreboard = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. After reset: start state, feet and inches.
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd0);           // start screen
      send_item(rtsd_pkg::CMD_SAMPLE, 24'hFFFFFF);      // start screen ignores the count
      send_item(rtsd_pkg::CMD_NONE, 24'd123);           // unused code, no effect
      send_item(rtsd_pkg::CMD_START, 24'hFFFFFF);       // start -> run
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd0);           // all zero: three blanks, rightmost 0
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd2499);        // just under one tenth
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd70000);       // 11 inches
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd762000);      // 9 feet 11 inches
      send_item(rtsd_pkg::CMD_SAMPLE, 24'hFFFFFF);      // feet past 99 wrap to two digits
      send_item(rtsd_pkg::CMD_NONE, 24'd0);
      send_item(rtsd_pkg::CMD_MODE, 24'd0);             // -> raw/250 mode
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd0);
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd249);
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd2500);        // 10
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd250250);      // 1001, inner zeros stay lit
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd2499999);     // 9999 exactly
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd2500000);     // saturates
      send_item(rtsd_pkg::CMD_SAMPLE, 24'hFFFFFF);      // saturates
      send_item(rtsd_pkg::CMD_START, 24'd0);            // run -> pause
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd500000);      // paused, no result
      send_item(rtsd_pkg::CMD_MODE, 24'hABCDEF);        // mode flips while paused
      send_item(rtsd_pkg::CMD_START, 24'd0);            // pause -> run
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd1000000);     // feet and inches again
      send_item(rtsd_pkg::CMD_MODE, 24'd0);
      send_item(rtsd_pkg::CMD_SAMPLE, 24'd1000000);

      // Random phases: slow receiver, then slow sender, then full rate.
      random_items(610);
      send_idle = 85;
      recv_idle = 7;
      random_items(610);
      send_idle = 0;
      recv_idle = 0;
      random_items(610);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Wait out the pipeline; a hang here is caught by the watchdog.
      while (scoreboard.pending_displays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/rtsd_pkg.sv
hw/rtl/rtsd_digits.sv
hw/rtl/range_to_seven_segment_display.sv
test/range_to_seven_segment_display_test.sv
